### rtl/ate_pkg.sv
// ate_pkg: shared types, sizes and helpers for the array table engine
// used by array_table_engine_top; no dependencies
`default_nettype none

package ate_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W   = CNT_W + 1;
  localparam int unsigned CMP_W   = CNT_W + 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 4;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_SORT   = 3'd2,
    KIND_READ   = 3'd3,
    KIND_SEARCH = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_DEL_RD,
    S_DEL_WR,
    S_SORT_LD,
    S_SORT_CUR,
    S_SORT_CMP,
    S_SORT_WB,
    S_STR_RD,
    S_STR_OUT,
    S_SRCH_RD,
    S_SRCH_CMP
  } state_e;

  // low index bits, zero-extended when the counter is narrower
  function automatic logic [IDX_W-1:0] to_idx(input logic [CNT_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (b < IDX_W) r[b] = v[b];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/ate_ram.sv
// ate_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none

module ate_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/array_table_engine_top.sv
// array_table_engine_top: packed table of signed words with insert, delete,
// exchange sort, read-out and search, run by one sequencer on a shared ram
// depends on ate_pkg and ate_ram
//
// usage: one request word on the input channel (kind, value, position);
// results leave on the output channel, one word each, last set on the final
// word of a request. in_ready_o is high only while the sequencer is idle;
// a finished word may still wait in the output register meanwhile.
// work per request, n = count: insert writes one word at the end, delete
// moves each entry above the position down one place, search reads the
// entries in order up to the first hit (all n on a miss), read streams all
// n entries, and sort runs an exchange pass per position, then streams.
// the pace is set by the single ram read port, which the sequencer uses
// for one table word at a time.
// reset clears the count and the control state; the table contents stay
// undefined and are used only below the count, so there is no clearing pass.
// when the receiver stalls, the output register holds its word and the
// sequencer waits in place.
`default_nettype none

module array_table_engine_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [3:0]  position_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic signed [31:0] element_o,
  output logic [3:0]       index_o,
  output logic             last_o
);

  localparam int unsigned AW    = ate_pkg::AW;
  localparam int unsigned CNT_W = ate_pkg::CNT_W;
  localparam int unsigned SUM_W = ate_pkg::SUM_W;
  localparam int unsigned CMP_W = ate_pkg::CMP_W;
  localparam int unsigned DW    = ate_pkg::DATA_W;
  localparam int unsigned IW    = ate_pkg::IDX_W;

  ate_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [DW-1:0]    cur_q, cur_d;
  logic [DW-1:0]    key_q, key_d;
  ate_pkg::status_e resp_status_q, resp_status_d;
  logic [CNT_W-1:0] resp_index_q, resp_index_d;

  logic             out_valid_q;
  logic             out_load;
  ate_pkg::status_e out_status_q, out_status_d;
  logic [DW-1:0]    out_element_q, out_element_d;
  logic [IW-1:0]    out_index_q, out_index_d;
  logic             out_last_q, out_last_d;
  logic             out_free;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DW-1:0]    ram_wdata, ram_rdata;

  logic [SUM_W-1:0] i_p1, i_p2, j_p1, k_p1, k_p2, count_ext;
  logic [CMP_W-1:0] pos_ext, pos_p1, count_cmp;
  logic             full, greater;

  ate_ram #(
    .WIDTH(DW),
    .DEPTH(ate_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign i_p1      = SUM_W'(i_q) + SUM_W'(1);
  assign i_p2      = SUM_W'(i_q) + SUM_W'(2);
  assign j_p1      = SUM_W'(j_q) + SUM_W'(1);
  assign k_p1      = SUM_W'(k_q) + SUM_W'(1);
  assign k_p2      = SUM_W'(k_q) + SUM_W'(2);
  assign count_ext = SUM_W'(count_q);
  assign pos_ext   = CMP_W'(position_i);
  assign pos_p1    = pos_ext + CMP_W'(1);
  assign count_cmp = CMP_W'(count_q);
  assign full      = (count_q == CNT_W'(ate_pkg::DEPTH));
  // the sort's compare unit
  assign greater   = $signed(cur_q) > $signed(ram_rdata);
  assign out_free  = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == ate_pkg::S_IDLE);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    i_d           = i_q;
    j_d           = j_q;
    k_d           = k_q;
    cur_d         = cur_q;
    key_d         = key_q;
    resp_status_d = resp_status_q;
    resp_index_d  = resp_index_q;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = cur_q;
    ram_raddr     = '0;
    out_load      = 1'b0;
    out_status_d  = ate_pkg::ST_OK;
    out_element_d = '0;
    out_index_d   = '0;
    out_last_d    = 1'b1;

    unique case (state_q)
      ate_pkg::S_IDLE: begin
        if (in_valid_i) begin
          key_d        = value_i;
          k_d          = '0;
          resp_index_d = '0;
          unique case (kind_i)
            ate_pkg::KIND_INSERT: begin
              if (full) begin
                resp_status_d = ate_pkg::ST_FULL;
              end else begin
                ram_we        = 1'b1;
                ram_waddr     = count_q[AW-1:0];
                ram_wdata     = value_i;
                count_d       = count_q + CNT_W'(1);
                resp_status_d = ate_pkg::ST_OK;
              end
              state_d = ate_pkg::S_RESP;
            end
            ate_pkg::KIND_DELETE: begin
              if (count_q == '0) begin
                resp_status_d = ate_pkg::ST_EMPTY;
                state_d       = ate_pkg::S_RESP;
              end else if (pos_ext >= count_cmp) begin
                resp_status_d = ate_pkg::ST_BAD_POS;
                state_d       = ate_pkg::S_RESP;
              end else if (pos_p1 < count_cmp) begin
                k_d     = CNT_W'(position_i);
                state_d = ate_pkg::S_DEL_RD;
              end else begin
                count_d       = count_q - CNT_W'(1);
                resp_status_d = ate_pkg::ST_OK;
                state_d       = ate_pkg::S_RESP;
              end
            end
            ate_pkg::KIND_SORT: begin
              if (count_q == '0) begin
                resp_status_d = ate_pkg::ST_EMPTY;
                state_d       = ate_pkg::S_RESP;
              end else if (count_q == CNT_W'(1)) begin
                state_d = ate_pkg::S_STR_RD;
              end else begin
                i_d     = '0;
                j_d     = CNT_W'(1);
                state_d = ate_pkg::S_SORT_LD;
              end
            end
            ate_pkg::KIND_READ: begin
              if (count_q == '0) begin
                resp_status_d = ate_pkg::ST_EMPTY;
                state_d       = ate_pkg::S_RESP;
              end else begin
                state_d = ate_pkg::S_STR_RD;
              end
            end
            ate_pkg::KIND_SEARCH: begin
              if (count_q == '0) begin
                resp_status_d = ate_pkg::ST_NOT_FOUND;
                state_d       = ate_pkg::S_RESP;
              end else begin
                state_d = ate_pkg::S_SRCH_RD;
              end
            end
            default: state_d = ate_pkg::S_IDLE;
          endcase
        end
      end

      ate_pkg::S_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = resp_status_q;
          out_index_d  = ate_pkg::to_idx(resp_index_q);
          state_d      = ate_pkg::S_IDLE;
        end
      end

      ate_pkg::S_DEL_RD: begin
        ram_raddr = k_p1[AW-1:0];
        state_d   = ate_pkg::S_DEL_WR;
      end

      ate_pkg::S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[AW-1:0];
        ram_wdata = ram_rdata;
        k_d       = CNT_W'(k_p1);
        if (k_p2 < count_ext) begin
          state_d = ate_pkg::S_DEL_RD;
        end else begin
          count_d       = count_q - CNT_W'(1);
          resp_status_d = ate_pkg::ST_OK;
          state_d       = ate_pkg::S_RESP;
        end
      end

      ate_pkg::S_SORT_LD: begin
        ram_raddr = i_q[AW-1:0];
        state_d   = ate_pkg::S_SORT_CUR;
      end

      ate_pkg::S_SORT_CUR: begin
        cur_d     = ram_rdata;
        ram_raddr = j_q[AW-1:0];
        state_d   = ate_pkg::S_SORT_CMP;
      end

      ate_pkg::S_SORT_CMP: begin
        ram_raddr = j_p1[AW-1:0];
        if (greater) begin
          ram_we    = 1'b1;
          ram_waddr = j_q[AW-1:0];
          ram_wdata = cur_q;
          cur_d     = ram_rdata;
        end
        if (j_p1 < count_ext) begin
          j_d = CNT_W'(j_p1);
        end else begin
          state_d = ate_pkg::S_SORT_WB;
        end
      end

      ate_pkg::S_SORT_WB: begin
        ram_we    = 1'b1;
        ram_waddr = i_q[AW-1:0];
        ram_wdata = cur_q;
        ram_raddr = i_p1[AW-1:0];
        i_d       = CNT_W'(i_p1);
        j_d       = CNT_W'(i_p2);
        if (i_p2 < count_ext) begin
          state_d = ate_pkg::S_SORT_CUR;
        end else begin
          k_d     = '0;
          state_d = ate_pkg::S_STR_RD;
        end
      end

      ate_pkg::S_STR_RD: begin
        ram_raddr = k_q[AW-1:0];
        state_d   = ate_pkg::S_STR_OUT;
      end

      ate_pkg::S_STR_OUT: begin
        ram_raddr = out_free ? k_p1[AW-1:0] : k_q[AW-1:0];
        if (out_free) begin
          out_load      = 1'b1;
          out_status_d  = ate_pkg::ST_OK;
          out_element_d = ram_rdata;
          out_index_d   = ate_pkg::to_idx(k_q);
          out_last_d    = (k_p1 == count_ext);
          k_d           = CNT_W'(k_p1);
          if (k_p1 == count_ext) begin
            state_d = ate_pkg::S_IDLE;
          end
        end
      end

      ate_pkg::S_SRCH_RD: begin
        ram_raddr = k_q[AW-1:0];
        state_d   = ate_pkg::S_SRCH_CMP;
      end

      ate_pkg::S_SRCH_CMP: begin
        ram_raddr = k_p1[AW-1:0];
        if (ram_rdata == key_q) begin
          resp_status_d = ate_pkg::ST_OK;
          resp_index_d  = k_q;
          state_d       = ate_pkg::S_RESP;
        end else if (k_p1 < count_ext) begin
          k_d = CNT_W'(k_p1);
        end else begin
          resp_status_d = ate_pkg::ST_NOT_FOUND;
          resp_index_d  = '0;
          state_d       = ate_pkg::S_RESP;
        end
      end

      default: state_d = ate_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ate_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q           <= i_d;
    j_q           <= j_d;
    k_q           <= k_d;
    cur_q         <= cur_d;
    key_q         <= key_d;
    resp_status_q <= resp_status_d;
    resp_index_q  <= resp_index_d;
    if (out_load) begin
      out_status_q  <= out_status_d;
      out_element_q <= out_element_d;
      out_index_q   <= out_index_d;
      out_last_q    <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign element_o   = out_element_q;
  assign index_o     = out_index_q;
  assign last_o      = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ate_pkg::DEPTH))
    else $error("element count above table depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == ate_pkg::KIND_INSERT) && !full
    |=> count_q == CNT_W'($past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the count");

  a_stream_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ate_pkg::S_STR_OUT) |-> (k_q < count_q))
    else $error("stream pointer past the count");

endmodule

`default_nettype wire

### test/array_table_engine_checker.sv
`timescale 1ns / 1ps
// array_table_engine_checker: watches both channels of the array table engine,
// keeps its own copy of the table and count, and compares result words in order
// depends on ate_pkg; instantiated beside the block by tb_array_table_engine_top
module array_table_engine_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         position_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         status_i,
  input  logic signed [31:0] element_i,
  input  logic [3:0]         index_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 words_due_o
);

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [3:0]         index;
    logic               last;
  } result_word_t;

  logic signed [31:0] entries_q [ate_pkg::DEPTH];
  int unsigned        count_q = 0;
  result_word_t       due_words [$];
  int                 fails = 0;

  task automatic push_word(input ate_pkg::status_e st, input logic signed [31:0] el,
                           input int unsigned idx, input logic lst);
    result_word_t w;
    w.status  = st;
    w.element = el;
    w.index   = idx[3:0];
    w.last    = lst;
    due_words.push_back(w);
  endtask

  task automatic stream_entries();
    if (count_q == 0) begin
      push_word(ate_pkg::ST_EMPTY, 32'sd0, 0, 1'b1);
    end else begin
      for (int unsigned i = 0; i < count_q; i++) begin
        push_word(ate_pkg::ST_OK, entries_q[i], i, (i + 1 == count_q));
      end
    end
  endtask

  task automatic apply_request(input logic [2:0] k, input logic signed [31:0] v,
                               input logic [3:0] p);
    logic signed [31:0] swap;
    bit                 hit;
    hit = 1'b0;
    case (k)
      ate_pkg::KIND_INSERT: begin
        if (count_q >= ate_pkg::DEPTH) begin
          push_word(ate_pkg::ST_FULL, 32'sd0, 0, 1'b1);
        end else begin
          entries_q[count_q] = v;
          count_q++;
          push_word(ate_pkg::ST_OK, 32'sd0, 0, 1'b1);
        end
      end
      ate_pkg::KIND_DELETE: begin
        if (count_q == 0) begin
          push_word(ate_pkg::ST_EMPTY, 32'sd0, 0, 1'b1);
        end else if (p >= count_q) begin
          push_word(ate_pkg::ST_BAD_POS, 32'sd0, 0, 1'b1);
        end else begin
          for (int unsigned i = p; i + 1 < count_q; i++) begin
            entries_q[i] = entries_q[i + 1];
          end
          count_q--;
          push_word(ate_pkg::ST_OK, 32'sd0, 0, 1'b1);
        end
      end
      ate_pkg::KIND_SORT: begin
        for (int unsigned i = 0; i < count_q; i++) begin
          for (int unsigned j = i + 1; j < count_q; j++) begin
            if (entries_q[i] > entries_q[j]) begin
              swap         = entries_q[i];
              entries_q[i] = entries_q[j];
              entries_q[j] = swap;
            end
          end
        end
        stream_entries();
      end
      ate_pkg::KIND_READ: stream_entries();
      ate_pkg::KIND_SEARCH: begin
        for (int unsigned i = 0; i < count_q; i++) begin
          if (!hit && entries_q[i] == v) begin
            hit = 1'b1;
            push_word(ate_pkg::ST_OK, 32'sd0, i, 1'b1);
          end
        end
        if (!hit) push_word(ate_pkg::ST_NOT_FOUND, 32'sd0, 0, 1'b1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : watch
    result_word_t got;
    result_word_t want;
    if (!rst_ni) begin
      count_q = 0;
      due_words.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {status_i, element_i, index_i, last_i};
        if (due_words.size() == 0) begin
          $display("%0t: word with none due, got status %0d element %0d index %0d last %0d",
                   $time, got.status, got.element, got.index, got.last);
          fails++;
        end else begin
          want = due_words.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fails++;
          end
          if (got.element !== want.element) begin
            $display("%0t: element expected %0d actual %0d", $time, want.element,
                     got.element);
            fails++;
          end
          if (got.index !== want.index) begin
            $display("%0t: index expected %0d actual %0d", $time, want.index, got.index);
            fails++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_request(kind_i, value_i, position_i);
    end
    fail_count_o <= fails;
    words_due_o  <= due_words.size();
  end

endmodule

### test/tb_array_table_engine_top.sv
`timescale 1ns / 1ps
// tb_array_table_engine_top: drives requests into array_table_engine_top with
// random idling on both sides and gives the verdict from the checker's count
// depends on ate_pkg, array_table_engine_top and array_table_engine_checker
module tb_array_table_engine_top;

  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS     = 340;
  localparam int QUIET_WORDS      = 40;
  localparam int PHASE_WORDS      = 40;
  localparam int LONG_HOLD_AT     = 600;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT      = 50000;
  localparam int TAIL_CYCLES      = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         kind;
  logic signed [31:0] value;
  logic [3:0]         position;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         status;
  logic signed [31:0] element;
  logic [3:0]         index;
  logic               last;
  logic               quiet;
  int                 fail_count;
  int                 words_due;

  always #5 clk_i = ~clk_i;

  array_table_engine_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .value_i     (value),
    .position_i  (position),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .element_o   (element),
    .index_o     (index),
    .last_o      (last)
  );

  array_table_engine_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .kind_i       (kind),
    .value_i      (value),
    .position_i   (position),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .status_i     (status),
    .element_i    (element),
    .index_i      (index),
    .last_i       (last),
    .fail_count_o (fail_count),
    .words_due_o  (words_due)
  );

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 2))
      0: pick_value = $signed($urandom_range(0, 15)) - 8;
      1: pick_value = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: pick_value = 32'sh7fffffff;
          1: pick_value = 32'sh80000000;
          2: pick_value = -32'sd1;
          default: pick_value = 32'sd0;
        endcase
      end
    endcase
  endfunction

  task automatic send_word(input logic [2:0] k, input logic signed [31:0] v,
                           input logic [3:0] p);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    position <= p;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // receiver: random stall bursts, calm stretches, one long hold-off
  initial begin : sink
    int  cyc;
    int  burst;
    int  hold;
    bit  calm;
    cyc   = 0;
    burst = 0;
    hold  = 0;
    calm  = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
      if (cyc % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stim
    bit          filling;
    int          r;
    int          wait_cnt;
    logic [2:0]  k;
    logic [3:0]  p;
    filling  = 1'b0;
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    kind     <= ate_pkg::KIND_INSERT;
    value    <= 32'sd0;
    position <= 4'd0;
    quiet    <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table
    send_word(ate_pkg::KIND_DELETE, 32'sd0, 4'd0);
    send_word(ate_pkg::KIND_READ,   32'sd0, 4'd0);
    send_word(ate_pkg::KIND_SORT,   32'sd0, 4'd0);
    send_word(ate_pkg::KIND_SEARCH, 32'sd0, 4'd0);
    // extremes, duplicate max
    send_word(ate_pkg::KIND_INSERT, 32'sh7fffffff, 4'd0);
    send_word(ate_pkg::KIND_INSERT, 32'sh80000000, 4'd0);
    send_word(ate_pkg::KIND_INSERT, -32'sd1, 4'd0);
    send_word(ate_pkg::KIND_INSERT, 32'sd0, 4'd0);
    send_word(ate_pkg::KIND_INSERT, 32'sd1, 4'd0);
    send_word(ate_pkg::KIND_INSERT, 32'sh7fffffff, 4'd0);
    send_word(ate_pkg::KIND_READ,   32'sd0, 4'd0);
    send_word(ate_pkg::KIND_SEARCH, 32'sh7fffffff, 4'd0);
    send_word(ate_pkg::KIND_SEARCH, 32'sd5, 4'd0);
    send_word(ate_pkg::KIND_DELETE, 32'sd0, 4'd15);
    send_word(ate_pkg::KIND_DELETE, 32'sd0, 4'd6);
    send_word(ate_pkg::KIND_SORT,   32'sd0, 4'd0);
    send_word(ate_pkg::KIND_SEARCH, 32'sh7fffffff, 4'd0);
    send_word(ate_pkg::KIND_DELETE, 32'sd0, 4'd5);
    send_word(ate_pkg::KIND_DELETE, 32'sd0, 4'd0);
    send_word(ate_pkg::KIND_READ,   32'sd0, 4'd0);
    send_word(KIND_SPARE_LO, 32'sh7fffffff, 4'd15);
    send_word(KIND_SPARE_HI, 32'sd0, 4'd0);
    send_word(ate_pkg::KIND_SEARCH, -32'sd1, 4'd0);

    // alternate fill-heavy and drain-heavy phases
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % PHASE_WORDS == 0) filling = !filling;
      if (n == RANDOM_WORDS - QUIET_WORDS) quiet <= 1'b1;
      r = $urandom_range(0, 99);
      if (filling) begin
        if (r < 70)      k = ate_pkg::KIND_INSERT;
        else if (r < 78) k = ate_pkg::KIND_SEARCH;
        else if (r < 84) k = ate_pkg::KIND_READ;
        else if (r < 90) k = ate_pkg::KIND_SORT;
        else if (r < 95) k = ate_pkg::KIND_DELETE;
        else             k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      end else begin
        if (r < 15)      k = ate_pkg::KIND_INSERT;
        else if (r < 60) k = ate_pkg::KIND_DELETE;
        else if (r < 72) k = ate_pkg::KIND_SEARCH;
        else if (r < 82) k = ate_pkg::KIND_READ;
        else if (r < 92) k = ate_pkg::KIND_SORT;
        else             k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      end
      p = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                      : 4'($urandom_range(0, 15));
      send_word(k, pick_value(), p);
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    do begin
      @(posedge clk_i);
      wait_cnt++;
    end while (words_due != 0 && wait_cnt < DRAIN_LIMIT);

    if (words_due != 0) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (fail_count == 0 && words_due == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
      $finish;
    end
  end

endmodule

### filelist.f
rtl/ate_pkg.sv
rtl/ate_ram.sv
rtl/array_table_engine_top.sv
test/array_table_engine_checker.sv
test/tb_array_table_engine_top.sv
